FILE: rtl/core/max_plus_graph_morphology_macros.svh
`ifndef MAX_PLUS_GRAPH_MORPHOLOGY_MACROS_SVH
`define MAX_PLUS_GRAPH_MORPHOLOGY_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted
`define MPGM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MPGM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mpgm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mpgm_pkg;

    localparam int MAX_PIXELS = 4096;
    localparam int MAX_EDGES  = 16384;
    localparam int VALUE_BITS = 24;

    localparam int PIX_AW  = $clog2(MAX_PIXELS);
    localparam int PIX_CW  = PIX_AW + 1;
    localparam int EDGE_AW = $clog2(MAX_EDGES);
    localparam int EDGE_CW = EDGE_AW + 1;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 14;
    localparam int NODE_W   = 12;
    localparam int PXCNT_W  = 13;
    localparam int EDCNT_W  = 15;
    localparam int LIMIT_W  = 8;
    localparam int MODE_W   = 2;
    localparam int CFGIDX_W = 2;
    localparam int CFGDAT_W = 15;

    typedef logic [PIX_AW-1:0]            t_pix_addr;
    typedef logic [EDGE_AW-1:0]           t_edge_addr;
    typedef logic signed [VALUE_BITS-1:0] t_value;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_PIXEL = 2'd0,
        OP_LOAD_EDGE  = 2'd1,
        OP_RUN        = 2'd2,
        OP_READ       = 2'd3
    } t_op;

    typedef enum logic [MODE_W-1:0] {
        MODE_DILATE = 2'd0,
        MODE_ERODE  = 2'd1,
        MODE_OPEN   = 2'd2,
        MODE_CLOSE  = 2'd3
    } t_mode;

    typedef enum logic [CFGIDX_W-1:0] {
        CFG_MODE        = 2'd0,
        CFG_ITER_LIMIT  = 2'd1,
        CFG_PIXEL_COUNT = 2'd2,
        CFG_EDGE_COUNT  = 2'd3
    } t_cfg_idx;

    localparam logic KIND_RUN  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_COPY,
        S_LOOP,
        S_EDGE_RD,
        S_EDGE_CHK,
        S_UPD1,
        S_RD2,
        S_UPD2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        t_value            gain;
    } t_edge;

    typedef struct packed {
        logic      src_we;
        t_pix_addr src_waddr;
        t_value    src_wdata;
        t_pix_addr src_raddr;
        logic      prev_we;
        t_pix_addr prev_waddr;
        t_value    prev_wdata;
        t_pix_addr prev_raddr0;
        t_pix_addr prev_raddr1;
        logic      cur_we;
        t_pix_addr cur_waddr;
        t_value    cur_wdata;
        t_pix_addr cur_raddr;
    } t_img_req;

endpackage
`default_nettype wire

FILE: rtl/core/mpgm_relax_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module mpgm_relax_unit (
    input  wire logic              i_erode,
    input  wire mpgm_pkg::t_value  i_prev,
    input  wire mpgm_pkg::t_value  i_gain,
    input  wire mpgm_pkg::t_value  i_cur,
    output logic                   o_update,
    output mpgm_pkg::t_value       o_value
);

    localparam int SW = mpgm_pkg::VALUE_BITS + 2;
    localparam logic signed [SW-1:0] VMAX = SW'((64'sd1 <<< (mpgm_pkg::VALUE_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] VMIN = -SW'(64'sd1 <<< (mpgm_pkg::VALUE_BITS - 1));

    logic signed [SW-1:0] sum;

    // candidate = prev +/- gain, saturated
    always_comb begin
        if (i_erode) begin
            sum = SW'(i_prev) - SW'(i_gain);
        end else begin
            sum = SW'(i_prev) + SW'(i_gain);
        end
        if (sum > VMAX) begin
            o_value = VMAX[mpgm_pkg::VALUE_BITS-1:0];
        end else if (sum < VMIN) begin
            o_value = VMIN[mpgm_pkg::VALUE_BITS-1:0];
        end else begin
            o_value = sum[mpgm_pkg::VALUE_BITS-1:0];
        end
        // max for dilation, min for erosion
        if (i_erode) begin
            o_update = (i_cur > o_value);
        end else begin
            o_update = (i_cur < o_value);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/mpgm_edge_store.sv
`timescale 1ns / 1ps
`default_nettype none
module mpgm_edge_store (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire mpgm_pkg::t_edge_addr  i_waddr,
    input  wire mpgm_pkg::t_edge       i_wdata,
    input  wire mpgm_pkg::t_edge_addr  i_raddr,
    output mpgm_pkg::t_edge            o_rdata
);

    mpgm_pkg::t_edge mem [mpgm_pkg::MAX_EDGES];

    // single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/mpgm_image_store.sv
`timescale 1ns / 1ps
`default_nettype none
module mpgm_image_store (
    input  wire logic                i_clk,
    input  wire mpgm_pkg::t_img_req  i_req,
    output mpgm_pkg::t_value         o_src_rdata,
    output mpgm_pkg::t_value         o_prev_rdata0,
    output mpgm_pkg::t_value         o_prev_rdata1,
    output mpgm_pkg::t_value         o_cur_rdata
);

    mpgm_pkg::t_value src_mem  [mpgm_pkg::MAX_PIXELS];
    mpgm_pkg::t_value prev_mem [mpgm_pkg::MAX_PIXELS];
    mpgm_pkg::t_value cur_mem  [mpgm_pkg::MAX_PIXELS];

    // source image
    always_ff @(posedge i_clk) begin
        if (i_req.src_we) begin
            src_mem[i_req.src_waddr] <= i_req.src_wdata;
        end
        o_src_rdata <= src_mem[i_req.src_raddr];
    end

    // previous image, two read ports
    always_ff @(posedge i_clk) begin
        if (i_req.prev_we) begin
            prev_mem[i_req.prev_waddr] <= i_req.prev_wdata;
        end
        o_prev_rdata0 <= prev_mem[i_req.prev_raddr0];
        o_prev_rdata1 <= prev_mem[i_req.prev_raddr1];
    end

    // current image
    always_ff @(posedge i_clk) begin
        if (i_req.cur_we) begin
            cur_mem[i_req.cur_waddr] <= i_req.cur_wdata;
        end
        o_cur_rdata <= cur_mem[i_req.cur_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/max_plus_graph_morphology.sv
`timescale 1ns / 1ps
`default_nettype none
// Max-plus morphology on a weighted pixel graph. Pixel loads and edge loads
// give no result; a read returns the pixel through the registered port of
// the current image. A run occupies the block until its result: each stage
// first copies N pixels (N = pixels in use), then each pass walks the edge
// store, relaxing each edge in range and skipping the rest, and copies the
// image back when the pass changed something. One shared add/saturate/compare
// unit serves both endpoint updates of every edge.
`include "max_plus_graph_morphology_macros.svh"
module max_plus_graph_morphology (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [mpgm_pkg::OP_W-1:0]            i_op,
    input  wire logic [mpgm_pkg::SLOT_W-1:0]          i_slot,
    input  wire logic signed [mpgm_pkg::VALUE_BITS-1:0] i_pixel_value,
    input  wire logic [mpgm_pkg::NODE_W-1:0]          i_node_a,
    input  wire logic [mpgm_pkg::NODE_W-1:0]          i_node_b,
    input  wire logic signed [mpgm_pkg::VALUE_BITS-1:0] i_edge_gain,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic                                      o_result_kind,
    output logic signed [mpgm_pkg::VALUE_BITS-1:0]    o_value_out,
    output logic [mpgm_pkg::LIMIT_W-1:0]              o_iterations_used,
    output logic                                      o_index_error,
    input  wire logic                                 i_cfg_we,
    input  wire logic [mpgm_pkg::CFGIDX_W-1:0]        i_cfg_index,
    input  wire logic [mpgm_pkg::CFGDAT_W-1:0]        i_cfg_data
);

    localparam logic [mpgm_pkg::PIX_CW-1:0]  PIX_MAX  = mpgm_pkg::PIX_CW'(mpgm_pkg::MAX_PIXELS);
    localparam logic [mpgm_pkg::EDGE_CW-1:0] EDGE_MAX = mpgm_pkg::EDGE_CW'(mpgm_pkg::MAX_EDGES);

    // configuration
    logic [mpgm_pkg::MODE_W-1:0]  r_mode;
    logic [mpgm_pkg::LIMIT_W-1:0] r_iter_limit;
    logic [mpgm_pkg::PXCNT_W-1:0] r_pix_count;
    logic [mpgm_pkg::EDCNT_W-1:0] r_edge_count;

    // sequencer state
    mpgm_pkg::t_state r_state, n_state;
    logic                          r_stage, n_stage;
    logic                          r_erode, n_erode;
    logic [mpgm_pkg::LIMIT_W-1:0]  r_limit, n_limit;
    logic [mpgm_pkg::LIMIT_W-1:0]  r_it, n_it;
    logic [mpgm_pkg::LIMIT_W-1:0]  r_k, n_k;
    logic                          r_change, n_change;
    logic                          r_pchg, n_pchg;
    logic                          r_err, n_err;
    logic                          r_from_cur, n_from_cur;
    logic [mpgm_pkg::PIX_CW-1:0]   r_idx, n_idx;
    logic                          r_cp_v, n_cp_v;
    mpgm_pkg::t_pix_addr           r_cp_addr, n_cp_addr;
    logic [mpgm_pkg::EDGE_CW-1:0]  r_l, n_l;
    logic [mpgm_pkg::NODE_W-1:0]   r_a, n_a;
    logic [mpgm_pkg::NODE_W-1:0]   r_b, n_b;
    mpgm_pkg::t_value              r_g, n_g;
    mpgm_pkg::t_value              r_px, n_px;
    logic                          r_rd_err, n_rd_err;

    // output register
    logic                          r_o_valid, n_o_valid;
    logic                          r_o_kind, n_o_kind;
    mpgm_pkg::t_value              r_o_value, n_o_value;
    logic [mpgm_pkg::LIMIT_W-1:0]  r_o_iters, n_o_iters;
    logic                          r_o_err, n_o_err;

    logic [mpgm_pkg::PIX_CW-1:0]   pix_used;
    logic [mpgm_pkg::EDGE_CW-1:0]  edges_used;
    logic                          in_xfer;
    logic                          out_free;

    mpgm_pkg::t_img_req            img_req;
    mpgm_pkg::t_value              src_rdata, prev_rdata0, prev_rdata1, cur_rdata;
    logic                          edge_we;
    mpgm_pkg::t_edge               edge_wdata, edge_rdata;
    mpgm_pkg::t_edge_addr          edge_raddr;

    logic                          ru_update;
    mpgm_pkg::t_value              ru_prev, ru_cur, ru_value;

    logic [mpgm_pkg::NODE_W-1:0]   e_x, e_y, r_x, r_y;
    logic [mpgm_pkg::LIMIT_W-1:0]  stage_k;
    mpgm_pkg::t_value              copy_data;

    assign pix_used   = (mpgm_pkg::PIX_CW'(r_pix_count) > PIX_MAX) ? PIX_MAX
                                                                 : mpgm_pkg::PIX_CW'(r_pix_count);
    assign edges_used = (r_edge_count > EDGE_MAX) ? EDGE_MAX : r_edge_count;
    assign o_in_ready = (r_state == mpgm_pkg::S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_o_valid || i_out_ready;

    // endpoint order: dilation updates a then b, erosion b then a
    assign e_x = r_erode ? edge_rdata.node_b : edge_rdata.node_a;
    assign e_y = r_erode ? edge_rdata.node_a : edge_rdata.node_b;
    assign r_x = r_erode ? r_b : r_a;
    assign r_y = r_erode ? r_a : r_b;
    assign stage_k   = r_change ? r_limit : (r_it - 1'b1);
    assign copy_data = r_from_cur ? cur_rdata : src_rdata;

    assign edge_we    = in_xfer && (i_op == mpgm_pkg::OP_LOAD_EDGE);
    assign edge_wdata = '{node_a: i_node_a, node_b: i_node_b, gain: i_edge_gain};

    assign o_out_valid       = r_o_valid;
    assign o_result_kind     = r_o_kind;
    assign o_value_out       = r_o_value;
    assign o_iterations_used = r_o_iters;
    assign o_index_error     = r_o_err;

    mpgm_image_store u_image (
        .i_clk         (i_clk),
        .i_req         (img_req),
        .o_src_rdata   (src_rdata),
        .o_prev_rdata0 (prev_rdata0),
        .o_prev_rdata1 (prev_rdata1),
        .o_cur_rdata   (cur_rdata)
    );

    mpgm_edge_store u_edges (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (i_slot[mpgm_pkg::EDGE_AW-1:0]),
        .i_wdata (edge_wdata),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    mpgm_relax_unit u_relax (
        .i_erode  (r_erode),
        .i_prev   (ru_prev),
        .i_gain   (r_g),
        .i_cur    (ru_cur),
        .o_update (ru_update),
        .o_value  (ru_value)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= mpgm_pkg::MODE_DILATE;
            r_iter_limit <= mpgm_pkg::LIMIT_W'(1);
            r_pix_count  <= mpgm_pkg::PXCNT_W'(mpgm_pkg::MAX_PIXELS);
            r_edge_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mpgm_pkg::CFG_MODE:        r_mode       <= i_cfg_data[mpgm_pkg::MODE_W-1:0];
                mpgm_pkg::CFG_ITER_LIMIT:  r_iter_limit <= i_cfg_data[mpgm_pkg::LIMIT_W-1:0];
                mpgm_pkg::CFG_PIXEL_COUNT: r_pix_count  <= i_cfg_data[mpgm_pkg::PXCNT_W-1:0];
                mpgm_pkg::CFG_EDGE_COUNT:  r_edge_count <= i_cfg_data[mpgm_pkg::EDCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mpgm_pkg::S_IDLE;
            r_o_valid <= 1'b0;
            r_cp_v    <= 1'b0;
            r_change  <= 1'b0;
            r_pchg    <= 1'b0;
            r_err     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_cp_v    <= n_cp_v;
            r_change  <= n_change;
            r_pchg    <= n_pchg;
            r_err     <= n_err;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_stage    <= n_stage;
        r_erode    <= n_erode;
        r_limit    <= n_limit;
        r_it       <= n_it;
        r_k        <= n_k;
        r_from_cur <= n_from_cur;
        r_idx      <= n_idx;
        r_cp_addr  <= n_cp_addr;
        r_l        <= n_l;
        r_a        <= n_a;
        r_b        <= n_b;
        r_g        <= n_g;
        r_px       <= n_px;
        r_rd_err   <= n_rd_err;
        r_o_kind   <= n_o_kind;
        r_o_value  <= n_o_value;
        r_o_iters  <= n_o_iters;
        r_o_err    <= n_o_err;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_stage    = r_stage;
        n_erode    = r_erode;
        n_limit    = r_limit;
        n_it       = r_it;
        n_k        = r_k;
        n_change   = r_change;
        n_pchg     = r_pchg;
        n_err      = r_err;
        n_from_cur = r_from_cur;
        n_idx      = r_idx;
        n_cp_v     = r_cp_v;
        n_cp_addr  = r_cp_addr;
        n_l        = r_l;
        n_a        = r_a;
        n_b        = r_b;
        n_g        = r_g;
        n_px       = r_px;
        n_rd_err   = r_rd_err;
        n_o_valid  = r_o_valid && !i_out_ready;
        n_o_kind   = r_o_kind;
        n_o_value  = r_o_value;
        n_o_iters  = r_o_iters;
        n_o_err    = r_o_err;

        img_req             = '0;
        img_req.src_waddr   = i_slot[mpgm_pkg::PIX_AW-1:0];
        img_req.src_wdata   = i_pixel_value;
        edge_raddr          = r_l[mpgm_pkg::EDGE_AW-1:0];
        ru_prev             = prev_rdata1;
        ru_cur              = cur_rdata;

        case (r_state)
            mpgm_pkg::S_IDLE: begin
                if (in_xfer) begin
                    case (i_op)
                        mpgm_pkg::OP_LOAD_PIXEL: begin
                            img_req.src_we = (i_slot < mpgm_pkg::SLOT_W'(pix_used));
                        end
                        mpgm_pkg::OP_RUN: begin
                            n_err      = 1'b0;
                            n_stage    = 1'b0;
                            n_erode    = (r_mode == mpgm_pkg::MODE_ERODE) ||
                                         (r_mode == mpgm_pkg::MODE_OPEN);
                            n_limit    = r_iter_limit;
                            n_from_cur = 1'b0;
                            n_idx      = '0;
                            n_cp_v     = 1'b0;
                            n_change   = 1'b1;
                            n_it       = '0;
                            n_state    = mpgm_pkg::S_COPY;
                        end
                        mpgm_pkg::OP_READ: begin
                            img_req.cur_raddr = i_slot[mpgm_pkg::PIX_AW-1:0];
                            // hold the address while the result waits
                            n_idx    = {1'b0, i_slot[mpgm_pkg::PIX_AW-1:0]};
                            n_rd_err = (i_slot >= mpgm_pkg::SLOT_W'(pix_used));
                            n_state  = mpgm_pkg::S_READ;
                        end
                        default: ;
                    endcase
                end
            end

            mpgm_pkg::S_READ: begin
                img_req.cur_raddr = r_idx[mpgm_pkg::PIX_AW-1:0];
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = mpgm_pkg::KIND_READ;
                    n_o_value = r_rd_err ? '0 : cur_rdata;
                    n_o_iters = '0;
                    n_o_err   = r_rd_err;
                    n_state   = mpgm_pkg::S_IDLE;
                end
            end

            // image copy into previous (and current when from source)
            mpgm_pkg::S_COPY: begin
                if (r_idx < pix_used) begin
                    img_req.src_raddr = r_idx[mpgm_pkg::PIX_AW-1:0];
                    img_req.cur_raddr = r_idx[mpgm_pkg::PIX_AW-1:0];
                    n_idx     = r_idx + 1'b1;
                    n_cp_v    = 1'b1;
                    n_cp_addr = r_idx[mpgm_pkg::PIX_AW-1:0];
                end else begin
                    n_cp_v = 1'b0;
                end
                if (r_cp_v) begin
                    img_req.prev_we    = 1'b1;
                    img_req.prev_waddr = r_cp_addr;
                    img_req.prev_wdata = copy_data;
                    img_req.cur_we     = !r_from_cur;
                    img_req.cur_waddr  = r_cp_addr;
                    img_req.cur_wdata  = copy_data;
                end
                if ((r_idx >= pix_used) && !r_cp_v) begin
                    n_state = mpgm_pkg::S_LOOP;
                end
            end

            // pass loop and stage sequencing
            mpgm_pkg::S_LOOP: begin
                if ((r_it < r_limit) && r_change) begin
                    n_it    = r_it + 1'b1;
                    n_l     = '0;
                    n_pchg  = 1'b0;
                    n_state = mpgm_pkg::S_EDGE_RD;
                end else if (!r_stage) begin
                    n_k = stage_k;
                    if (((r_mode == mpgm_pkg::MODE_OPEN) || (r_mode == mpgm_pkg::MODE_CLOSE))
                        && (stage_k == r_limit)) begin
                        n_stage    = 1'b1;
                        n_erode    = !r_erode;
                        n_limit    = stage_k;
                        n_from_cur = 1'b1;
                        n_idx      = '0;
                        n_cp_v     = 1'b0;
                        n_change   = 1'b1;
                        n_it       = '0;
                        n_state    = mpgm_pkg::S_COPY;
                    end else begin
                        n_state = mpgm_pkg::S_DONE;
                    end
                end else begin
                    n_state = mpgm_pkg::S_DONE;
                end
            end

            mpgm_pkg::S_EDGE_RD: begin
                if (r_l >= edges_used) begin
                    n_change = r_pchg;
                    if (r_pchg) begin
                        n_from_cur = 1'b1;
                        n_idx      = '0;
                        n_cp_v     = 1'b0;
                        n_state    = mpgm_pkg::S_COPY;
                    end else begin
                        n_state = mpgm_pkg::S_LOOP;
                    end
                end else begin
                    n_state = mpgm_pkg::S_EDGE_CHK;
                end
            end

            // range check, fetch both previous values and first current value
            mpgm_pkg::S_EDGE_CHK: begin
                if ((mpgm_pkg::PIX_CW'(edge_rdata.node_a) >= pix_used) ||
                    (mpgm_pkg::PIX_CW'(edge_rdata.node_b) >= pix_used)) begin
                    n_err   = 1'b1;
                    n_l     = r_l + 1'b1;
                    n_state = mpgm_pkg::S_EDGE_RD;
                end else begin
                    n_a = edge_rdata.node_a;
                    n_b = edge_rdata.node_b;
                    n_g = edge_rdata.gain;
                    img_req.prev_raddr0 = e_x[mpgm_pkg::PIX_AW-1:0];
                    img_req.prev_raddr1 = e_y[mpgm_pkg::PIX_AW-1:0];
                    img_req.cur_raddr   = e_x[mpgm_pkg::PIX_AW-1:0];
                    n_state = mpgm_pkg::S_UPD1;
                end
            end

            mpgm_pkg::S_UPD1: begin
                ru_prev = prev_rdata1;
                ru_cur  = cur_rdata;
                n_px    = prev_rdata0;
                if (ru_update) begin
                    img_req.cur_we    = 1'b1;
                    img_req.cur_waddr = r_x[mpgm_pkg::PIX_AW-1:0];
                    img_req.cur_wdata = ru_value;
                    n_pchg = 1'b1;
                end
                n_state = mpgm_pkg::S_RD2;
            end

            mpgm_pkg::S_RD2: begin
                img_req.cur_raddr = r_y[mpgm_pkg::PIX_AW-1:0];
                n_state = mpgm_pkg::S_UPD2;
            end

            mpgm_pkg::S_UPD2: begin
                ru_prev = r_px;
                ru_cur  = cur_rdata;
                if (ru_update) begin
                    img_req.cur_we    = 1'b1;
                    img_req.cur_waddr = r_y[mpgm_pkg::PIX_AW-1:0];
                    img_req.cur_wdata = ru_value;
                    n_pchg = 1'b1;
                end
                n_l     = r_l + 1'b1;
                n_state = mpgm_pkg::S_EDGE_RD;
            end

            mpgm_pkg::S_DONE: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = mpgm_pkg::KIND_RUN;
                    n_o_value = '0;
                    n_o_iters = r_k;
                    n_o_err   = r_err;
                    n_state   = mpgm_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = mpgm_pkg::S_IDLE;
            end
        endcase
    end

    // checks
    `MPGM_ASSERT_NOW(a_pass_bound, i_clk, i_rst_n, r_state == mpgm_pkg::S_LOOP, r_it <= r_limit, "pass count beyond limit")
    `MPGM_ASSERT_NOW(a_edge_in_range, i_clk, i_rst_n, r_state == mpgm_pkg::S_UPD1, (mpgm_pkg::PIX_CW'(r_a) < pix_used) && (mpgm_pkg::PIX_CW'(r_b) < pix_used), "relaxing an out-of-range edge")
    `MPGM_ASSERT_NEXT(a_run_busy, i_clk, i_rst_n, in_xfer && (i_op == mpgm_pkg::OP_RUN), !o_in_ready, "run accepted without going busy")
    `MPGM_ASSERT_NEXT(a_upd_order, i_clk, i_rst_n, r_state == mpgm_pkg::S_UPD1, r_state == mpgm_pkg::S_RD2, "second endpoint update skipped")

endmodule
`default_nettype wire
